>>> rtl/core/chc_pkg.sv
// Shared types, constants and the arctangent table of the compass heading block.
// Depends on nothing; every other file imports it.
`default_nettype none

package chc_pkg;

  // Number of CORDIC rotations per sample (valid range 8 to 24).
  localparam int CordicSteps = 16;
  // The square roots of 24-bit sums settle in 12 digit steps.
  localparam int SqrtSteps   = 12;
  localparam int IterSteps   = (CordicSteps > SqrtSteps) ? CordicSteps : SqrtSteps;
  localparam int CntW        = $clog2(IterSteps);
  localparam int AtanIdxW    = 5;
  localparam int AtanW       = 18;

  localparam int SampW  = 12;
  localparam int DiffW  = SampW + 1;
  localparam int VecW   = 24;
  localparam int AngW   = 23;
  localparam int SqW    = 2 * SampW - 1;
  localparam int SumW   = 2 * SampW;
  localparam int RootW  = SampW;
  localparam int WrapW  = 25;
  localparam int HeadW  = 15;

  // Angles inside the CORDIC are in 1/4096 degree.
  localparam int Deg180   = 737280;
  localparam int Deg360   = 1474560;
  localparam int FullTurn = 5760;

  localparam logic [1:0] RegOffsetX     = 2'd0;
  localparam logic [1:0] RegOffsetY     = 2'd1;
  localparam logic [1:0] RegDeclination = 2'd2;

  typedef struct packed {
    logic signed [11:0] mag_x;
    logic signed [11:0] mag_y;
    logic signed [11:0] mag_z;
  } chc_in_t;

  typedef struct packed {
    logic        [12:0] heading;
    logic        [11:0] magnitude_xy;
    logic        [11:0] magnitude_xyz;
    logic signed [11:0] estimate_x;
    logic signed [11:0] estimate_y;
    logic signed [11:0] estimate_z;
  } chc_out_t;

  typedef struct packed {
    logic            load;
    logic            step;
    logic [CntW-1:0] idx;
  } chc_iter_ctrl_t;

  // atan(2^-i) in 1/4096 degree, rounded.
  function automatic logic [AtanW-1:0] atan_tab(input logic [AtanIdxW-1:0] i);
    logic [AtanW-1:0] val;
    case (i)
      5'd0:    val = 18'd184320;
      5'd1:    val = 18'd108810;
      5'd2:    val = 18'd57492;
      5'd3:    val = 18'd29184;
      5'd4:    val = 18'd14649;
      5'd5:    val = 18'd7331;
      5'd6:    val = 18'd3667;
      5'd7:    val = 18'd1833;
      5'd8:    val = 18'd917;
      5'd9:    val = 18'd458;
      5'd10:   val = 18'd229;
      5'd11:   val = 18'd115;
      5'd12:   val = 18'd57;
      5'd13:   val = 18'd29;
      5'd14:   val = 18'd14;
      5'd15:   val = 18'd7;
      5'd16:   val = 18'd4;
      5'd17:   val = 18'd2;
      5'd18:   val = 18'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/compass_heading_calibration.sv
// Compass heading and hard-iron calibration, top level with register port.
// Depends on chc_pkg and chc_iter.
//
// Usage: a sample (mag_x, mag_y, mag_z) is one transaction on the in channel
// (valid/ready). Each sample yields one transaction on the out channel with
// the heading (1/16 degree, 0..5759), the floored magnitudes of the raw x/y
// and x/y/z vectors, and the hard-iron estimates floor((max+min)/2) per axis
// after this sample has updated the running extremes.
// Steps in order: the squares, loading the datapath, the iterations of the
// shared CORDIC/root unit, adding the declination, the modulo reduction and
// loading the output register, which raises out_valid_o.
// The block takes one sample at a time; in_ready_o is high only when idle,
// so a new sample is taken only once the last result is in the output register.
// If the receiver stalls, the finished result waits in the output register
// and the block takes the next sample; that sample's result waits in the
// final reduction step until the output register is free.
// Reset clears the offsets and declination to zero and the extremes to
// their empty values. Registers: offset_x at 0x0, offset_y at 0x4,
// declination at 0x8; write them only while the block is idle.
`default_nettype none

module compass_heading_calibration import chc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire chc_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output chc_out_t         out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StSquare = 6'b000010,
    StSum    = 6'b000100,
    StIter   = 6'b001000,
    StWrap   = 6'b010000,
    StMod    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic signed [11:0] off_x_q, off_y_q;
  logic signed [12:0] decl_q;
  logic signed [11:0] lo_x_q, lo_y_q, lo_z_q, hi_x_q, hi_y_q, hi_z_q;

  chc_in_t                samp_q;
  logic signed [DiffW-1:0] dx_q, dy_q;
  logic [SqW-1:0]         sq_x_q, sq_y_q, sq_z_q;
  logic signed [11:0]     est_x_q, est_y_q, est_z_q;
  logic [CntW-1:0]        cnt_q;
  logic [HeadW-1:0]       head_q;
  chc_out_t               out_q;
  logic                   out_valid_q;

  logic                   in_fire, out_free, cfg_write;
  chc_iter_ctrl_t         iter_ctrl;
  logic [SumW-1:0]        sum_xy, sum_xyz;
  logic signed [AngW-1:0] angle;
  logic [RootW-1:0]       root_xy, root_xyz;
  logic signed [23:0]     prod_x, prod_y, prod_z;
  logic signed [12:0]     mid_x, mid_y, mid_z;
  logic signed [WrapW-1:0] wrap_sum;
  logic                   out_load;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      RegOffsetX:     prdata = 32'($signed(off_x_q));
      RegOffsetY:     prdata = 32'($signed(off_y_q));
      RegDeclination: prdata = 32'($signed(decl_q));
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      decl_q  <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        RegOffsetX:     off_x_q <= pwdata[11:0];
        RegOffsetY:     off_y_q <= pwdata[11:0];
        RegDeclination: decl_q  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Running extremes are updated at the edge that takes the sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_x_q <= 12'sd2047;
      lo_y_q <= 12'sd2047;
      lo_z_q <= 12'sd2047;
      hi_x_q <= -12'sd2048;
      hi_y_q <= -12'sd2048;
      hi_z_q <= -12'sd2048;
    end else if (in_fire) begin
      if (in_data_i.mag_x < lo_x_q) lo_x_q <= in_data_i.mag_x;
      if (in_data_i.mag_y < lo_y_q) lo_y_q <= in_data_i.mag_y;
      if (in_data_i.mag_z < lo_z_q) lo_z_q <= in_data_i.mag_z;
      if (in_data_i.mag_x > hi_x_q) hi_x_q <= in_data_i.mag_x;
      if (in_data_i.mag_y > hi_y_q) hi_y_q <= in_data_i.mag_y;
      if (in_data_i.mag_z > hi_z_q) hi_z_q <= in_data_i.mag_z;
    end
  end

  assign prod_x = samp_q.mag_x * samp_q.mag_x;
  assign prod_y = samp_q.mag_y * samp_q.mag_y;
  assign prod_z = samp_q.mag_z * samp_q.mag_z;

  assign mid_x = {hi_x_q[11], hi_x_q} + {lo_x_q[11], lo_x_q};
  assign mid_y = {hi_y_q[11], hi_y_q} + {lo_y_q[11], lo_y_q};
  assign mid_z = {hi_z_q[11], hi_z_q} + {lo_z_q[11], lo_z_q};

  assign sum_xy  = SumW'(sq_x_q) + SumW'(sq_y_q);
  assign sum_xyz = sum_xy + SumW'(sq_z_q);

  // The bias of two full turns keeps the sum positive for any declination.
  assign wrap_sum = WrapW'(angle) + WrapW'($signed({decl_q, 8'b0}))
                  + WrapW'(2 * Deg360 + 128);

  always_comb begin
    iter_ctrl.load = (state_q == StSum);
    iter_ctrl.step = (state_q == StIter);
    iter_ctrl.idx  = cnt_q;
  end

  chc_iter u_iter (
    .clk_i      (clk_i),
    .ctrl_i     (iter_ctrl),
    .dx_i       (dx_q),
    .dy_i       (dy_q),
    .sum_xy_i   (sum_xy),
    .sum_xyz_i  (sum_xyz),
    .angle_o    (angle),
    .root_xy_o  (root_xy),
    .root_xyz_o (root_xyz)
  );

  assign out_load = (state_q == StMod) && (head_q < HeadW'(FullTurn)) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_fire) state_d = StSquare;
      StSquare: state_d = StSum;
      StSum:    state_d = StIter;
      StIter:   if (cnt_q == CntW'(IterSteps - 1)) state_d = StWrap;
      StWrap:   state_d = StMod;
      StMod:    if (out_load) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIter) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      samp_q <= in_data_i;
      dx_q   <= $signed({in_data_i.mag_x[11], in_data_i.mag_x}) - $signed({off_x_q[11], off_x_q});
      dy_q   <= $signed({in_data_i.mag_y[11], in_data_i.mag_y}) - $signed({off_y_q[11], off_y_q});
    end
    if (state_q == StSquare) begin
      sq_x_q  <= prod_x[SqW-1:0];
      sq_y_q  <= prod_y[SqW-1:0];
      sq_z_q  <= prod_z[SqW-1:0];
      est_x_q <= mid_x[12:1];
      est_y_q <= mid_y[12:1];
      est_z_q <= mid_z[12:1];
    end
    if (state_q == StWrap) begin
      head_q <= wrap_sum[HeadW+7:8];
    end else if ((state_q == StMod) && (head_q >= HeadW'(FullTurn))) begin
      head_q <= head_q - HeadW'(FullTurn);
    end
    if (out_load) begin
      out_q.heading       <= head_q[12:0];
      out_q.magnitude_xy  <= root_xy;
      out_q.magnitude_xyz <= root_xyz;
      out_q.estimate_x    <= est_x_q;
      out_q.estimate_y    <= est_y_q;
      out_q.estimate_z    <= est_z_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/chc_iter.sv
// Iterative datapath: one vectoring CORDIC rotation and one square-root digit
// of each magnitude per step, up to CordicSteps and SqrtSteps. Depends on chc_pkg.
`default_nettype none

module chc_iter import chc_pkg::*; (
  input  wire logic                   clk_i,
  input  wire chc_iter_ctrl_t         ctrl_i,
  input  wire logic signed [DiffW-1:0] dx_i,
  input  wire logic signed [DiffW-1:0] dy_i,
  input  wire logic [SumW-1:0]        sum_xy_i,
  input  wire logic [SumW-1:0]        sum_xyz_i,
  output logic signed [AngW-1:0]      angle_o,
  output logic [RootW-1:0]            root_xy_o,
  output logic [RootW-1:0]            root_xyz_o
);

  logic signed [VecW-1:0] x_q, x_d, y_q, y_d;
  logic signed [AngW-1:0] ang_q, ang_d;
  logic [SumW-1:0]        nxy_q, nxy_d, nxyz_q, nxyz_d;
  logic [SumW-1:0]        rxy_q, rxy_d, rxyz_q, rxyz_d;
  logic [SumW-1:0]        bit_q, bit_d;

  logic signed [VecW-1:0] x0, y0, xs, ys;
  logic signed [AngW-1:0] step_ang;
  logic [SumW:0]          txy, txyz;
  logic                   cordic_en, sqrt_en;

  assign x0 = VecW'($signed({dx_i, 8'b0}));
  assign y0 = VecW'($signed({dy_i, 8'b0}));
  assign xs = x_q >>> ctrl_i.idx;
  assign ys = y_q >>> ctrl_i.idx;
  assign step_ang = AngW'($signed({1'b0, atan_tab(AtanIdxW'(ctrl_i.idx))}));

  assign cordic_en = ({1'b0, ctrl_i.idx} < (CntW + 1)'(CordicSteps));
  assign sqrt_en   = ({1'b0, ctrl_i.idx} < (CntW + 1)'(SqrtSteps));

  assign txy  = {1'b0, rxy_q} + {1'b0, bit_q};
  assign txyz = {1'b0, rxyz_q} + {1'b0, bit_q};

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    ang_d  = ang_q;
    nxy_d  = nxy_q;
    nxyz_d = nxyz_q;
    rxy_d  = rxy_q;
    rxyz_d = rxyz_q;
    bit_d  = bit_q;
    if (ctrl_i.load) begin
      // A vector in the left half plane is turned by 180 degrees first.
      if (dx_i < 0) begin
        x_d   = -x0;
        y_d   = -y0;
        ang_d = AngW'(Deg180);
      end else begin
        x_d   = x0;
        y_d   = y0;
        ang_d = '0;
      end
      nxy_d  = sum_xy_i;
      nxyz_d = sum_xyz_i;
      rxy_d  = '0;
      rxyz_d = '0;
      bit_d  = SumW'(1) << (2 * (SqrtSteps - 1));
    end else if (ctrl_i.step) begin
      if (cordic_en) begin
        if (y_q > 0) begin
          x_d   = x_q + ys;
          y_d   = y_q - xs;
          ang_d = ang_q + step_ang;
        end else if (y_q < 0) begin
          x_d   = x_q - ys;
          y_d   = y_q + xs;
          ang_d = ang_q - step_ang;
        end
      end
      if (sqrt_en) begin
        if ({1'b0, nxy_q} >= txy) begin
          nxy_d = nxy_q - txy[SumW-1:0];
          rxy_d = (rxy_q >> 1) + bit_q;
        end else begin
          rxy_d = rxy_q >> 1;
        end
        if ({1'b0, nxyz_q} >= txyz) begin
          nxyz_d = nxyz_q - txyz[SumW-1:0];
          rxyz_d = (rxyz_q >> 1) + bit_q;
        end else begin
          rxyz_d = rxyz_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    ang_q  <= ang_d;
    nxy_q  <= nxy_d;
    nxyz_q <= nxyz_d;
    rxy_q  <= rxy_d;
    rxyz_q <= rxyz_d;
    bit_q  <= bit_d;
  end

  assign angle_o    = ang_q;
  assign root_xy_o  = rxy_q[RootW-1:0];
  assign root_xyz_o = rxyz_q[RootW-1:0];

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for compass_heading_calibration: drives samples and
// register writes, predicts heading, magnitudes and offset estimates per sample.
// Depends on chc_pkg and the compass_heading_calibration RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import chc_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 30;
  localparam int MaxPrinted = 50;
  localparam longint HalfTurn = 737280;
  localparam longint WholeTurn = 1474560;
  localparam longint TurnSteps = 5760;

  // atan(2^-i) in 1/4096 degree.
  localparam longint ArcTable [24] = '{
    184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0, 0, 0, 0, 0
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  chc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready;
  chc_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the registers and the running extremes.
  logic signed [11:0] cal_offset_x = '0;
  logic signed [11:0] cal_offset_y = '0;
  logic signed [12:0] cal_declination = '0;
  longint low_x = 2047, low_y = 2047, low_z = 2047;
  longint high_x = -2048, high_y = -2048, high_z = -2048;

  chc_out_t heading_queue [$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  bit       idle_on = 1'b1;
  int       hold_request = 0;

  compass_heading_calibration uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint floor_root(input longint n);
    longint root;
    longint trial;
    int b;
    root = 0;
    for (b = 12; b >= 0; b--) begin
      trial = root + (longint'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Works out the result of one sample and advances the running extremes.
  function automatic chc_out_t predict_fix(input chc_in_t s);
    chc_out_t r;
    longint sx, sy, sz, vx, vy, ang, tx, ty, acc;
    int i;
    sx = s.mag_x;
    sy = s.mag_y;
    sz = s.mag_z;
    if (sx < low_x) low_x = sx;
    if (sy < low_y) low_y = sy;
    if (sz < low_z) low_z = sz;
    if (sx > high_x) high_x = sx;
    if (sy > high_y) high_y = sy;
    if (sz > high_z) high_z = sz;

    vx = (sx - longint'(cal_offset_x)) * 256;
    vy = (sy - longint'(cal_offset_y)) * 256;
    ang = 0;
    if (vx != 0 || vy != 0) begin
      // Fold the left half plane onto the right one before rotating.
      if (vx < 0) begin
        vx = -vx;
        vy = -vy;
        ang = HalfTurn;
      end
      for (i = 0; i < CordicSteps; i++) begin
        tx = vx >>> i;
        ty = vy >>> i;
        if (vy > 0) begin
          vx += ty;
          vy -= tx;
          ang += ArcTable[i];
        end else if (vy < 0) begin
          vx -= ty;
          vy += tx;
          ang -= ArcTable[i];
        end
      end
    end
    acc = ang + longint'(cal_declination) * 256 + 2 * WholeTurn + 128;
    acc = (acc >>> 8) % TurnSteps;
    r.heading = acc[12:0];
    acc = floor_root(sx * sx + sy * sy);
    r.magnitude_xy = acc[11:0];
    acc = floor_root(sx * sx + sy * sy + sz * sz);
    r.magnitude_xyz = acc[11:0];
    acc = (high_x + low_x) >>> 1;
    r.estimate_x = acc[11:0];
    acc = (high_y + low_y) >>> 1;
    r.estimate_y = acc[11:0];
    acc = (high_z + low_z) >>> 1;
    r.estimate_z = acc[11:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < MaxPrinted)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Result checker: every accepted transaction is matched with the oldest prediction.
  always @(posedge clk) begin
    chc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (heading_queue.size() == 0) begin
        report_mismatch("unexpected transaction, heading", out_data.heading, -1);
      end else begin
        want = heading_queue.pop_front();
        if (out_data.heading != want.heading)
          report_mismatch("heading", out_data.heading, want.heading);
        if (out_data.magnitude_xy != want.magnitude_xy)
          report_mismatch("magnitude_xy", out_data.magnitude_xy, want.magnitude_xy);
        if (out_data.magnitude_xyz != want.magnitude_xyz)
          report_mismatch("magnitude_xyz", out_data.magnitude_xyz, want.magnitude_xyz);
        if (out_data.estimate_x != want.estimate_x)
          report_mismatch("estimate_x", out_data.estimate_x, want.estimate_x);
        if (out_data.estimate_y != want.estimate_y)
          report_mismatch("estimate_y", out_data.estimate_y, want.estimate_y);
        if (out_data.estimate_z != want.estimate_z)
          report_mismatch("estimate_z", out_data.estimate_z, want.estimate_z);
      end
    end
  end

  // Receiver: random stall bursts (while idle_on), plus a long hold-off when a test asks for one.
  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back samples need no gap.
  task automatic send_sample(input int x, input int y, input int z);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.mag_x = x[11:0];
    in_data.mag_y = y[11:0];
    in_data.mag_z = z[11:0];
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    heading_queue.push_back(predict_fix(in_data));
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [1:0] index, input int value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {index, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic wait_until_idle();
    in_valid = 1'b0;
    while (heading_queue.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Registers are only written once every pending result has come back.
  task automatic set_calibration(input int ox, input int oy, input int decl);
    wait_until_idle();
    apb_write(RegOffsetX, ox);
    cal_offset_x = ox[11:0];
    apb_write(RegOffsetY, oy);
    cal_offset_y = oy[11:0];
    apb_write(RegDeclination, decl);
    cal_declination = decl[12:0];
  endtask

  task automatic test_axis_extremes();
    send_sample(0, 0, 0);
    send_sample(2047, 2047, 2047);
    send_sample(-2048, -2048, -2048);
    send_sample(2047, 0, 0);
    send_sample(-2048, 0, 0);
    send_sample(0, 2047, 1);
    send_sample(0, -2048, -1);
    send_sample(-1, 0, 0);
    send_sample(1, -1, 0);
    // Just below a full turn, which must wrap to zero.
    send_sample(2047, -1, 0);
    send_sample(-2048, 1, 0);
    send_sample(-1, -1, 5);
    send_sample(3, 4, 12);
  endtask

  task automatic test_register_extremes();
    set_calibration(2047, -2048, 2879);
    send_sample(-2048, 2047, 0);
    send_sample(2047, -2048, 0);
    set_calibration(-2048, 2047, -2880);
    send_sample(2047, -2048, 7);
    send_sample(-2048, 2047, 0);
    // The largest and smallest declinations still wrap fully.
    set_calibration(-2048, 2047, 4095);
    send_sample(-2048, 2047, -3);
    set_calibration(100, -50, -4096);
    send_sample(100, -50, 9);
    send_sample(2047, 2047, -2048);
  endtask

  task automatic test_random_phase(input int count, input int span, input int ox,
                                   input int oy, input int decl);
    int n, sel, x, y, z;
    set_calibration(ox, oy, decl);
    for (n = 0; n < count; n++) begin
      sel = $urandom_range(0, 19);
      x = int'($urandom_range(0, 2 * span - 1)) - span;
      y = int'($urandom_range(0, 2 * span - 1)) - span;
      z = int'($urandom_range(0, 2 * span - 1)) - span;
      if (sel == 0) begin
        x = int'(cal_offset_x);
        y = int'(cal_offset_y);
      end else if (sel == 1) begin
        x = int'(cal_offset_x);
      end else if (sel == 2) begin
        y = int'(cal_offset_y);
      end else if (sel == 3) begin
        x = int'(cal_offset_x) + int'($urandom_range(0, 6)) - 3;
        y = int'(cal_offset_y) + int'($urandom_range(0, 6)) - 3;
      end
      send_sample(x, y, z);
    end
  endtask

  task automatic test_output_backpressure();
    int n;
    wait_until_idle();
    hold_request = 300;
    for (n = 0; n < 25; n++)
      send_sample(int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                  int'($urandom_range(0, 4095)) - 2048);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_phase(100, 2048, int'($urandom_range(0, 4095)) - 2048,
                      int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 8191)) - 4096);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_axis_extremes();
    test_register_extremes();
    // Spans grow so the running extremes keep moving for a while.
    test_random_phase(120, 64, 0, 0, 0);
    test_random_phase(120, 512, -2048, 2047, -2880);
    test_random_phase(120, 2048, 2047, -2048, 2879);
    test_random_phase(120, 2048, int'($urandom_range(0, 4095)) - 2048,
                      int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 5759)) - 2880);
    test_random_phase(120, 2048, int'($urandom_range(0, 4095)) - 2048,
                      int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 8191)) - 4096);
    test_output_backpressure();
    test_back_to_back();
    in_valid = 1'b0;
    while (heading_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
